/* src/ghm_pkg.sv */
// Package with types and constants of the grid heat map histogram.
package ghm_pkg;

  localparam int unsigned MaxCells   = 4096;
  localparam int unsigned CellAw     = $clog2(MaxCells);
  localparam int unsigned CountWidth = 32;
  localparam int unsigned OccWidth   = $clog2(MaxCells + 1);
  localparam int unsigned CfgAw      = 3;
  localparam int unsigned CfgDw      = 32;

  localparam logic [1:0] ReqAdd   = 2'd0;
  localparam logic [1:0] ReqRead  = 2'd1;
  localparam logic [1:0] ReqClear = 2'd2;

  localparam logic [2:0] StCounted  = 3'd0;
  localparam logic [2:0] StOutside  = 3'd1;
  localparam logic [2:0] StInverted = 3'd2;
  localparam logic [2:0] StRead     = 3'd3;
  localparam logic [2:0] StCleared  = 3'd4;

  localparam logic [CfgAw-1:0] CfgLowX  = 3'd0;
  localparam logic [CfgAw-1:0] CfgLowY  = 3'd1;
  localparam logic [CfgAw-1:0] CfgHighX = 3'd2;
  localparam logic [CfgAw-1:0] CfgHighY = 3'd3;
  localparam logic [CfgAw-1:0] CfgCols  = 3'd4;
  localparam logic [CfgAw-1:0] CfgRows  = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [11:0]        cell_select;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] cell_number;
    logic [31:0] cell_count;
    logic [31:0] max_count;
    logic [12:0] nonempty_cells;
  } rsp_t;

  // Handshake between the control unit and the divider.
  typedef struct packed {
    logic        start;
    logic [38:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

/* src/ghm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module ghm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghm_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [38:0]       quot_o
);
  import ghm_pkg::*;

  logic [38:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[38]};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd39;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = 32'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[37:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[37:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

/* src/ghm_store.sv */
// Cell count memory with a registered read port.
module ghm_store (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [ghm_pkg::CellAw-1:0]      rd_addr_i,
  output logic [ghm_pkg::CountWidth-1:0]  rd_data_o,
  input  logic                            wr_en_i,
  input  logic [ghm_pkg::CellAw-1:0]      wr_addr_i,
  input  logic [ghm_pkg::CountWidth-1:0]  wr_data_i
);
  import ghm_pkg::*;

  logic [CountWidth-1:0] mem [MaxCells];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule

/* src/grid_heat_map_histogram.sv */
// Top level of the grid heat map histogram.
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  request   | start_i, busy_o, req_i               | in (busy_o out)
//  result    | done_o, rsp_o                        | out
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i      | in
//
// An add transaction that lands in the box passes from acceptance through the
// box test, two serial divisions of 39 quotient bits each that share one
// divider, the row first and the column after it, and the read and the write
// back of the cell memory. The result strobe and the return to idle fall in
// the same cycle. A dropped point answers from the box test, and a read from
// its single read-out state. A clear answers straight from idle and then keeps
// busy_o high for a sweep that writes zero to every entry; the same sweep runs
// after reset. Results cannot be stalled: done_o marks one cycle with rsp_o
// valid.
module grid_heat_map_histogram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  ghm_pkg::req_t              req_i,
  output logic                       done_o,
  output ghm_pkg::rsp_t              rsp_o,
  input  logic                       cfg_we_i,
  input  logic [ghm_pkg::CfgAw-1:0]  cfg_idx_i,
  input  logic [ghm_pkg::CfgDw-1:0]  cfg_data_i
);
  import ghm_pkg::*;

  // Each clear request sweeps zeros through the whole memory.
  localparam logic [3:0] SSweep = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SDivR  = 4'd2;
  localparam logic [3:0] SDivRw = 4'd3;
  localparam logic [3:0] SDivCw = 4'd4;
  localparam logic [3:0] SRead  = 4'd5;
  localparam logic [3:0] SRmw   = 4'd6;
  localparam logic [3:0] SRdOut = 4'd7;

  logic signed [31:0] lx_q, ly_q, hx_q, hy_q;
  logic [6:0]         cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q   <= '0;
      ly_q   <= '0;
      hx_q   <= 32'sd65536;
      hy_q   <= 32'sd65536;
      cols_q <= 7'd64;
      rows_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLowX:  lx_q   <= cfg_data_i;
        CfgLowY:  ly_q   <= cfg_data_i;
        CfgHighX: hx_q   <= cfg_data_i;
        CfgHighY: hy_q   <= cfg_data_i;
        CfgCols:  cols_q <= cfg_data_i[6:0];
        CfgRows:  rows_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  function automatic logic [6:0] clamp_n(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'd64) return 7'd64;
    return v;
  endfunction

  logic [6:0] ncol, nrow;
  assign ncol = clamp_n(cols_q);
  assign nrow = clamp_n(rows_q);

  logic [3:0]  st_q, st_d;
  logic [CellAw-1:0] sw_q, sw_d;
  req_t        req_q, req_d;
  logic [6:0]  col_q, col_d, row_q, row_d;
  logic [31:0] spx_q, spx_d;
  logic [CountWidth-1:0] max_q, max_d;
  logic [OccWidth-1:0]   occ_q, occ_d;
  logic        done_q, done_d;
  rsp_t        rsp_q, rsp_d;
  logic [CellAw-1:0] cell_q, cell_d;

  div_req_t    dreq;
  logic        ddone;
  logic [38:0] dquot;

  ghm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  logic              rd_en, wr_en;
  logic [CellAw-1:0] rd_addr, wr_addr;
  logic [CountWidth-1:0] rd_data, wr_data;

  ghm_store u_store (
    .clk_i, .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  logic signed [32:0] offx, offy, spanx, spany;
  assign offx  = 33'(req_q.point_x) - 33'(lx_q);
  assign offy  = 33'(req_q.point_y) - 33'(ly_q);
  assign spanx = 33'(hx_q) - 33'(lx_q);
  assign spany = 33'(hy_q) - 33'(ly_q);

  logic [6:0]  qsat;
  logic [CountWidth-1:0] cnt, cnt_new;
  logic [11:0] cellsum;

  always_comb begin
    st_d    = st_q;
    sw_d    = sw_q;
    req_d   = req_q;
    col_d   = col_q;
    row_d   = row_q;
    spx_d   = spx_q;
    max_d   = max_q;
    occ_d   = occ_q;
    cell_d  = cell_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    dreq    = '0;
    rd_en   = 1'b0;
    rd_addr = cell_q;
    wr_en   = 1'b0;
    wr_addr = cell_q;
    wr_data = '0;
    qsat    = (dquot > 39'd63) ? 7'd63 : dquot[6:0];
    cnt     = rd_data;
    cnt_new = cnt;
    // Row below 64 and at most 64 columns keep the sum within 12 bits.
    cellsum = 12'(row_q) * 12'(ncol) + 12'(col_q);
    case (st_q)
      SSweep: begin
        wr_en   = 1'b1;
        wr_addr = sw_q;
        sw_d    = sw_q + 1'b1;
        if (sw_q == CellAw'(MaxCells - 1)) st_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          req_d = req_i;
          case (req_i.req_type)
            ReqClear: begin
              max_d = '0;
              occ_d = '0;
              sw_d  = '0;
              rsp_d = '0;
              rsp_d.status = StCleared;
              done_d = 1'b1;
              st_d  = SSweep;
            end
            ReqAdd: st_d = SDivR;
            default: begin
              cell_d = req_i.cell_select[CellAw-1:0];
              rd_en  = 1'b1;
              rd_addr = req_i.cell_select[CellAw-1:0];
              st_d   = SRdOut;
            end
          endcase
        end
      end
      SDivR: begin
        rsp_d = '0;
        if (hx_q < lx_q || hy_q < ly_q) begin
          rsp_d.status = StInverted;
          rsp_d.max_count = max_q;
          rsp_d.nonempty_cells = 13'(occ_q);
          done_d = 1'b1;
          st_d = SIdle;
        end else if (req_q.point_x < lx_q || req_q.point_x > hx_q ||
                     req_q.point_y < ly_q || req_q.point_y > hy_q) begin
          rsp_d.status = StOutside;
          rsp_d.max_count = max_q;
          rsp_d.nonempty_cells = 13'(occ_q);
          done_d = 1'b1;
          st_d = SIdle;
        end else begin
          spx_d = spanx[31:0];
          dreq.start    = 1'b1;
          dreq.dividend = 39'(offy[31:0]) * 39'(nrow);
          dreq.divisor  = spany[31:0];
          if (spany == '0) dreq.divisor = 32'd1;
          if (spany == '0) dreq.dividend = '0;
          st_d = SDivRw;
        end
      end
      SDivRw: begin
        if (ddone) begin
          row_d = (qsat >= nrow) ? nrow - 7'd1 : qsat;
          dreq.start    = 1'b1;
          dreq.dividend = 39'(offx[31:0]) * 39'(ncol);
          dreq.divisor  = (spx_q == '0) ? 32'd1 : spx_q;
          if (spx_q == '0) dreq.dividend = '0;
          st_d = SDivCw;
        end
      end
      SDivCw: begin
        if (ddone) begin
          col_d = (qsat >= ncol) ? ncol - 7'd1 : qsat;
          st_d  = SRead;
        end
      end
      SRead: begin
        cell_d  = cellsum[CellAw-1:0];
        rd_en   = 1'b1;
        rd_addr = cellsum[CellAw-1:0];
        st_d    = SRmw;
      end
      SRmw: begin
        if (cnt != '1) begin
          cnt_new = cnt + 1'b1;
          wr_en   = 1'b1;
          wr_data = cnt_new;
          if (cnt_new == CountWidth'(1) && occ_q < OccWidth'(MaxCells))
            occ_d = occ_q + 1'b1;
        end
        if (cnt_new > max_q) max_d = cnt_new;
        rsp_d.status = StCounted;
        rsp_d.cell_number = 12'(cell_q);
        rsp_d.cell_count = cnt_new;
        rsp_d.max_count = (cnt_new > max_q) ? cnt_new : max_q;
        rsp_d.nonempty_cells = 13'(occ_d);
        done_d = 1'b1;
        st_d = SIdle;
      end
      SRdOut: begin
        rsp_d.status = StRead;
        rsp_d.cell_number = req_q.cell_select;
        rsp_d.cell_count = cnt;
        rsp_d.max_count = max_q;
        rsp_d.nonempty_cells = 13'(occ_q);
        done_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SSweep;
      sw_q   <= '0;
      max_q  <= '0;
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      sw_q   <= sw_d;
      max_q  <= max_d;
      occ_q  <= occ_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    col_q  <= col_d;
    row_q  <= row_d;
    spx_q  <= spx_d;
    cell_q <= cell_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (st_q != SIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule

/* src/ghm_checker.sv */
// Port checker for the grid heat map histogram, bound to the top level.
module ghm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input ghm_pkg::rsp_t rsp_o
);
  import ghm_pkg::*;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("transaction not taken");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.status <= StCleared) else $error("bad status");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == StCleared |-> rsp_o.max_count == '0 &&
    rsp_o.nonempty_cells == '0) else $error("clear left counts");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == StCounted |-> rsp_o.cell_count <= rsp_o.max_count)
    else $error("count above maximum");
endmodule

bind grid_heat_map_histogram ghm_checker u_ghm_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .rsp_o
);

/* tb/sv/tb_grid_heat_map_histogram.sv */
// Self-checking testbench for the grid heat map histogram.
`timescale 1ns / 1ps

module tb_grid_heat_map_histogram;
  import ghm_pkg::*;

  // Request type 3 is not named in the package; the block treats it as a read.
  localparam logic [1:0] ReqSpare   = 2'd3;
  localparam int unsigned CycleLimit = 4000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  req_t                 req_i = '0;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgAw-1:0]     cfg_idx_i = CfgLowX;
  logic [CfgDw-1:0]     cfg_data_i = '0;

  grid_heat_map_histogram i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the histogram state and of the configuration registers.
  logic [31:0]        tally [MaxCells];
  logic [31:0]        peak_count;
  logic [12:0]        occupied;
  logic signed [31:0] low_x, low_y, high_x, high_y;
  logic [6:0]         col_reg, row_reg;

  // Results still owed by the block, oldest first.
  rsp_t               owed_q[$];
  int unsigned        mismatches = 0;
  int unsigned        cycles = 0;

  function automatic longint unsigned clamp_buckets(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // Bucket index of an offset within a span. The upper edge lands in the
  // last bucket and a zero-width span always maps to bucket zero.
  function automatic longint unsigned bucket_index(longint off, longint span,
                                                   longint unsigned n);
    longint unsigned b;
    if (span <= 0) return 0;
    b = (longint'(off) * n) / span;
    if (b >= n) b = n - 1;
    return b;
  endfunction

  // Applies one request to the shadow state and returns the result it owes.
  function automatic rsp_t tally_request(req_t r);
    rsp_t            o;
    longint          px, py;
    longint unsigned nc, nr, slot;
    logic [31:0]     cnt;
    o = '0;
    px = r.point_x;
    py = r.point_y;
    case (r.req_type)
      ReqClear: begin
        foreach (tally[i]) tally[i] = '0;
        peak_count = '0;
        occupied   = '0;
        o.status   = StCleared;
        return o;
      end
      ReqAdd: begin
        if (high_x < low_x || high_y < low_y) begin
          o.status = StInverted;
        end else if (px < low_x || px > high_x || py < low_y || py > high_y) begin
          o.status = StOutside;
        end else begin
          nc   = clamp_buckets(col_reg);
          nr   = clamp_buckets(row_reg);
          slot = (bucket_index(py - low_y, longint'(high_y) - low_y, nr) * nc +
                  bucket_index(px - low_x, longint'(high_x) - low_x, nc)) % MaxCells;
          cnt  = tally[slot];
          if (cnt != 32'hFFFF_FFFF) begin
            cnt = cnt + 32'd1;
            tally[slot] = cnt;
            if (cnt == 1 && occupied < MaxCells) occupied = occupied + 13'd1;
          end
          if (cnt > peak_count) peak_count = cnt;
          o.status      = StCounted;
          o.cell_number = slot[11:0];
          o.cell_count  = cnt;
        end
      end
      default: begin
        o.status      = StRead;
        o.cell_number = r.cell_select;
        o.cell_count  = tally[r.cell_select];
      end
    endcase
    o.max_count      = peak_count;
    o.nonempty_cells = occupied;
    return o;
  endfunction

  // Every result is compared with the oldest owed one, field by field.
  always @(posedge clk_i) begin
    rsp_t want;
    if (done_o) begin
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", rsp_o);
      end else begin
        want = owed_q.pop_front();
        if (rsp_o.status !== want.status || rsp_o.cell_number !== want.cell_number ||
            rsp_o.cell_count !== want.cell_count || rsp_o.max_count !== want.max_count ||
            rsp_o.nonempty_cells !== want.nonempty_cells) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, rsp_o);
        end
      end
    end
  end

  // Watchdog; the budget covers the clearing sweeps, after reset and after
  // any clear, and every item at the slowest add with the longest sender gap,
  // several times over.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL grid_heat_map_histogram");
      $finish;
    end
  end

  // Sends one request transaction after an idle gap. Start stays high from one
  // transaction to the next when the gap is zero.
  task automatic send_request(req_t r, int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i = 1'b1;
    req_i   = r;
    do @(posedge clk_i); while (busy_o);
    owed_q.push_back(tally_request(r));
  endtask

  // Waits until the block has answered everything and has gone idle,
  // including a clearing sweep that follows a clear.
  task automatic drain;
    @(negedge clk_i);
    start_i = 1'b0;
    wait (owed_q.size() == 0);
    do @(negedge clk_i); while (busy_o);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(logic [CfgAw-1:0] idx, logic [31:0] data);
    drain();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgLowX:  low_x   = data;
      CfgLowY:  low_y   = data;
      CfgHighX: high_x  = data;
      CfgHighY: high_y  = data;
      CfgCols:  col_reg = data[6:0];
      CfgRows:  row_reg = data[6:0];
      default: ;
    endcase
  endtask

  task automatic write_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] hx,
                           logic [31:0] hy, logic [6:0] nc, logic [6:0] nr);
    write_reg(CfgLowX, lx);
    write_reg(CfgLowY, ly);
    write_reg(CfgHighX, hx);
    write_reg(CfgHighY, hy);
    write_reg(CfgCols, {25'd0, nc});
    write_reg(CfgRows, {25'd0, nr});
  endtask

  function automatic req_t make_req(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                                    logic [11:0] sel);
    req_t r;
    r.req_type    = kind;
    r.point_x     = x;
    r.point_y     = y;
    r.cell_select = sel;
    return r;
  endfunction

  // Reset values of the box: the unit square split into 64 by 64 buckets.
  // Corners, the upper edge, points just outside and every request type.
  task automatic test_default_box;
    send_request(make_req(ReqAdd, 0, 0, 0), 0);
    send_request(make_req(ReqAdd, 32'h0001_0000, 32'h0001_0000, 0), 3);
    send_request(make_req(ReqAdd, 32'h0000_8000, 32'h0000_4000, 0), 0);
    send_request(make_req(ReqAdd, 32'hFFFF_FFFF, 0, 0), 13);
    send_request(make_req(ReqAdd, 0, 32'h0001_0001, 0), 0);
    send_request(make_req(ReqAdd, 32'h0001_0000, 32'h0001_0000, 0), 1);
    send_request(make_req(ReqRead, 0, 0, 12'd0), 0);
    send_request(make_req(ReqSpare, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF), 2);
    send_request(make_req(ReqClear, 0, 0, 0), 0);
    send_request(make_req(ReqRead, 0, 0, 12'hFFF), 0);
  endtask

  // The widest possible box, a zero-width box, an inverted box and bucket
  // counts outside 1..64.
  task automatic test_box_extremes;
    write_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd64, 7'd64);
    send_request(make_req(ReqAdd, 32'h8000_0000, 32'h8000_0000, 0), 0);
    send_request(make_req(ReqAdd, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0);
    send_request(make_req(ReqAdd, 32'h8000_0000, 32'h7FFF_FFFF, 0), 5);
    write_box(32'd5, 32'd5, 32'd5, 32'd5, 7'd17, 7'd3);
    send_request(make_req(ReqAdd, 32'd5, 32'd5, 0), 0);
    send_request(make_req(ReqAdd, 32'd6, 32'd5, 0), 0);
    write_box(32'd10, 0, 32'hFFFF_FFF6, 32'd100, 7'd8, 7'd8);
    send_request(make_req(ReqAdd, 0, 32'd50, 0), 0);
    write_box(0, 0, 32'h0001_0000, 32'h0001_0000, 7'd0, 7'd127);
    send_request(make_req(ReqAdd, 32'h0001_0000, 32'h0001_0000, 0), 0);
    send_request(make_req(ReqAdd, 0, 32'h0000_8000, 0), 7);
    send_request(make_req(ReqRead, 0, 0, 12'd63), 0);
  endtask

  function automatic logic [31:0] point_in(logic signed [31:0] lo, logic signed [31:0] hi);
    longint span;
    span = longint'(hi) - lo;
    if (span < 0) return $urandom;
    case ($urandom_range(0, 9))
      0:       return lo;
      1:       return hi;
      default: return 32'(longint'(lo) + (longint'($urandom) % (span + 1)));
    endcase
  endfunction

  // Random phases, each with its own box and bucket counts. Most requests are
  // adds inside the box so that counts build up; the rest are reads, noise
  // points, rare clears and the spare request type.
  task automatic test_random_phases;
    logic signed [31:0] lo [2], hi [2];
    longint             top;
    int unsigned        pick, gap;
    bit                 burst;
    logic [11:0]        cells;
    for (int ph = 0; ph < 8; ph++) begin
      for (int a = 0; a < 2; a++) begin
        lo[a] = $urandom;
        case ($urandom_range(0, 3))
          0:       top = longint'(lo[a]) + $urandom_range(0, 2000);
          1:       top = longint'(lo[a]) + $urandom_range(0, 32'h00FF_FFFF);
          default: top = longint'(lo[a]) + $urandom;
        endcase
        hi[a] = (top > 64'sd2147483647) ? 32'h7FFF_FFFF : 32'(top);
      end
      if (ph == 5) hi[1] = lo[1] - 1 + (lo[1] == 32'h8000_0000);
      if (ph == 5 && hi[1] >= lo[1]) begin
        lo[1] = 32'd1;
        hi[1] = 32'd0;
      end
      write_box(lo[0], lo[1], hi[0], hi[1],
                ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64)),
                ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64)));
      cells = 12'(clamp_buckets(col_reg) * clamp_buckets(row_reg) - 1);
      burst = 1'b0;
      for (int n = 0; n < 90; n++) begin
        if ($urandom_range(0, 15) == 0) burst = ~burst;
        gap  = burst ? 0 : $urandom_range(0, 13);
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_request(make_req(ReqAdd, point_in(lo[0], hi[0]), point_in(lo[1], hi[1]),
                                12'($urandom)), gap);
        else if (pick < 80)
          send_request(make_req(ReqAdd, $urandom, $urandom, 12'($urandom)), gap);
        else if (pick < 92)
          send_request(make_req(ReqRead, $urandom, $urandom,
                                12'($urandom_range(0, cells))), gap);
        else if (pick < 95)
          send_request(make_req(ReqRead, $urandom, $urandom, 12'($urandom)), gap);
        else if (pick < 97)
          send_request(make_req(ReqClear, $urandom, $urandom, 12'($urandom)), gap);
        else
          send_request(make_req(ReqSpare, $urandom, $urandom,
                                12'($urandom_range(0, cells))), gap);
      end
    end
  endtask

  initial begin
    foreach (tally[i]) tally[i] = '0;
    peak_count = '0;
    occupied   = '0;
    low_x      = 0;
    low_y      = 0;
    high_x     = 32'sh0001_0000;
    high_y     = 32'sh0001_0000;
    col_reg    = 7'd64;
    row_reg    = 7'd64;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_box();
    test_box_extremes();
    test_random_phases();
    drain();

    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("PASS grid_heat_map_histogram");
    end else begin
      $display("FAIL grid_heat_map_histogram");
    end
    $finish;
  end

endmodule

/* grid_heat_map_histogram.f */
src/ghm_pkg.sv
src/ghm_div.sv
src/ghm_store.sv
src/grid_heat_map_histogram.sv
src/ghm_checker.sv
tb/sv/tb_grid_heat_map_histogram.sv
